@@ design/srsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package srsw_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SEQ_W      = 31;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int WSZ_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd1;

  localparam logic [1:0] ACT_ROUND = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_NEW   = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [SEQ_W-1:0] ack_seq;
    logic             checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] send_seq;
    logic             first_send;
    logic             transfer_done;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ROUND,
    CMD_ACK,
    CMD_NEW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [SEQ_W-1:0] seq;
    logic             ok;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SLIDE,
    B_CHECK,
    B_WALK,
    B_FLUSH
  } back_state_t;

  // window size register as used: zero means one, saturate at the slot count
  function automatic logic [WIN_W-1:0] eff_window(input logic [WSZ_W-1:0] ws);
    logic [WIN_W-1:0] w;
    if (ws == '0) begin
      w = WIN_W'(1);
    end else if (32'(ws) > MAX_WINDOW) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = WIN_W'(ws);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

@@ design/srsw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module srsw_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_push,
  output logic                     in_full,
  input  wire srsw_pkg::in_item_t  in_data,
  output logic                     cmd_valid,
  input  wire                logic cmd_pop,
  output srsw_pkg::cmd_t           cmd_data
);
  import srsw_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq;
  logic       deq;
  cmd_t       cmd_new;
  logic       keep;

  // decode the action; the unused code is taken and dropped
  always_comb begin
    cmd_new      = '0;
    cmd_new.seq  = in_data.ack_seq;
    cmd_new.ok   = in_data.checksum_ok;
    keep         = 1'b1;
    case (in_data.action)
      ACT_ROUND: cmd_new.kind = CMD_ROUND;
      ACT_ACK:   cmd_new.kind = CMD_ACK;
      ACT_NEW:   cmd_new.kind = CMD_NEW;
      default: begin
        cmd_new.kind = CMD_ROUND;
        keep         = 1'b0;
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rd_ptr_r];
  assign enq       = in_push && !in_full && keep;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ enq;
    rd_ptr_nxt = rd_ptr_r ^ deq;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

@@ design/srsw_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module srsw_outq (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic push,
  input  wire srsw_pkg::out_item_t  push_data,
  output logic                      full,
  output logic                      empty,
  input  wire                 logic pop,
  output srsw_pkg::out_item_t       pop_data
);
  import srsw_pkg::*;

  out_item_t  q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       wr;
  logic       rd;

  assign full     = (cnt_r == 3'd4);
  assign empty    = (cnt_r == 3'd0);
  assign pop_data = q_r[rd_ptr_r];
  assign wr       = push && !full;
  assign rd       = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + {1'b0, wr};
    rd_ptr_nxt = rd_ptr_r + {1'b0, rd};
    cnt_nxt    = cnt_r + {2'b0, wr} - {2'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ design/srsw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module srsw_back (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire srsw_pkg::cfg_wr_t    cfg_wr,
  input  wire                 logic cmd_valid,
  output logic                      cmd_pop,
  input  wire srsw_pkg::cmd_t       cmd_data,
  output logic                      out_push,
  output srsw_pkg::out_item_t       out_item,
  input  wire                 logic out_full
);
  import srsw_pkg::*;

  back_state_t           state_r, state_nxt;
  logic [WSZ_W-1:0]      wsize_r;
  logic [SEQ_W-1:0]      total_r;
  logic [SEQ_W-1:0]      base_r, base_nxt;
  logic [SEQ_W-1:0]      nu_r, nu_nxt;
  logic [MAX_WINDOW-1:0] mark_r, mark_nxt;
  logic [WIN_W-1:0]      cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]      s_r, s_nxt;
  logic [SEQ_W-1:0]      end_r, end_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [SEQ_W-1:0]      pend_seq_r, pend_seq_nxt;
  logic                  pend_first_r, pend_first_nxt;

  logic [WIN_W-1:0]      weff;
  logic                  base_done;
  logic                  base_marked;
  logic                  slide_stop;
  logic                  cur_marked;
  logic                  walk_end;
  logic                  ack_in_win;
  logic [SEQ_W:0]        end_sum;
  logic [SEQ_W-1:0]      end_calc;
  logic                  flush_stall;

  assign weff        = eff_window(wsize_r);
  assign base_done   = (base_r >= total_r);
  assign base_marked = mark_r[base_r[SLOT_W-1:0]];
  assign slide_stop  = (cnt_r == weff) || base_done || !base_marked;
  assign cur_marked  = mark_r[s_r[SLOT_W-1:0]];
  assign walk_end    = (s_r == end_r);
  assign flush_stall = pend_valid_r && out_full;

  // seq in [base, min(base+W, total)) without forming the end
  assign ack_in_win = cmd_data.ok && (cmd_data.seq >= base_r) && (cmd_data.seq < total_r) &&
                      ((cmd_data.seq - base_r) < SEQ_W'(weff));

  assign end_sum  = {1'b0, base_r} + (SEQ_W + 1)'(weff);
  assign end_calc = (end_sum > {1'b0, total_r}) ? total_r : end_sum[SEQ_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid && cmd_data.kind == CMD_ROUND) begin
          state_nxt = B_SLIDE;
        end
      end
      B_SLIDE: begin
        if (slide_stop) begin
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (!base_done) begin
          state_nxt = B_WALK;
        end else if (!out_full) begin
          state_nxt = B_IDLE;
        end
      end
      B_WALK: begin
        if (walk_end) begin
          state_nxt = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (!flush_stall) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    out_item       = '0;
    base_nxt       = base_r;
    nu_nxt         = nu_r;
    mark_nxt       = mark_r;
    cnt_nxt        = cnt_r;
    s_nxt          = s_r;
    end_nxt        = end_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    pend_first_nxt = pend_first_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd_data.kind)
            CMD_NEW: begin
              base_nxt = '0;
              nu_nxt   = '0;
              mark_nxt = '0;
            end
            CMD_ACK: begin
              if (ack_in_win) begin
                mark_nxt[cmd_data.seq[SLOT_W-1:0]] = 1'b1;
              end
            end
            CMD_ROUND: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      B_SLIDE: begin
        if (!slide_stop) begin
          mark_nxt[base_r[SLOT_W-1:0]] = 1'b0;
          base_nxt = base_r + SEQ_W'(1);
          cnt_nxt  = cnt_r + WIN_W'(1);
        end
      end
      B_CHECK: begin
        if (base_done) begin
          out_push               = !out_full;
          out_item.transfer_done = 1'b1;
          out_item.last_of_run   = 1'b1;
        end else begin
          end_nxt = end_calc;
          s_nxt   = base_r;
        end
      end
      B_WALK: begin
        // hold one send back so the final one can carry last_of_run
        if (!walk_end) begin
          if (cur_marked) begin
            s_nxt = s_r + SEQ_W'(1);
          end else if (!flush_stall) begin
            out_push            = pend_valid_r;
            out_item.send_valid = 1'b1;
            out_item.send_seq   = pend_seq_r;
            out_item.first_send = pend_first_r;
            pend_valid_nxt      = 1'b1;
            pend_seq_nxt        = s_r;
            pend_first_nxt      = (s_r >= nu_r);
            s_nxt               = s_r + SEQ_W'(1);
          end
        end
      end
      B_FLUSH: begin
        if (!flush_stall) begin
          out_push             = pend_valid_r;
          out_item.send_valid  = 1'b1;
          out_item.send_seq    = pend_seq_r;
          out_item.first_send  = pend_first_r;
          out_item.last_of_run = 1'b1;
          pend_valid_nxt       = 1'b0;
          if (end_r > nu_r) begin
            nu_nxt = end_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      wsize_r      <= WSZ_W'(1);
      total_r      <= '0;
      base_r       <= '0;
      nu_r         <= '0;
      mark_r       <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      nu_r         <= nu_nxt;
      mark_r       <= mark_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_wr.we && cfg_wr.index == REG_WINDOW_SIZE) begin
        wsize_r <= cfg_wr.data[WSZ_W-1:0];
      end
      if (cfg_wr.we && cfg_wr.index == REG_TOTAL_PACKETS) begin
        total_r <= cfg_wr.data[SEQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    end_r        <= end_nxt;
    pend_seq_r   <= pend_seq_nxt;
    pend_first_r <= pend_first_nxt;
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result transfer into a full queue");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == B_WALK || state_r == B_FLUSH))
    else $error("held send outside of window walk");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (s_r <= end_r))
    else $error("walk ran past window end");

  a_slide_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SLIDE) |-> (cnt_r <= weff))
    else $error("slide exceeded window size");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == B_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule
`default_nettype wire

@@ design/selective_repeat_sender_window.sv @@
// Ack and new-message transfers: queued, then applied by the engine when it takes them in idle.
// The engine takes one per cycle while it is idle.
// Round: a dispatch, then a slide past acknowledged entries (at most the window size), a check,
// then, unless the transfer is done, a walk over the window's sequence numbers and a flush.
// Sends are pushed in the walk and flush, which stall while a held send meets a full queue.
// Reset (rst_n low, synchronous): queues emptied, window and all marks cleared at once.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_sender_window (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic in_push,
  output logic                      in_full,
  input  wire srsw_pkg::in_item_t   in_data,
  output logic                      out_empty,
  input  wire                 logic out_pop,
  output srsw_pkg::out_item_t       out_data,
  input  wire                 logic cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srsw_pkg::*;

  cmd_t      cmd_data;
  logic      cmd_valid;
  logic      cmd_pop;
  out_item_t res_item;
  logic      res_push;
  logic      res_full;
  cfg_wr_t   cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  srsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  srsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .out_push  (res_push),
    .out_item  (res_item),
    .out_full  (res_full)
  );

  srsw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .empty     (out_empty),
    .pop       (out_pop),
    .pop_data  (out_data)
  );

endmodule
`default_nettype wire
